@@ rtl/core/bdo_pkg.sv @@
// Shared types and constants for the brick decomposition block.
// Used by the divider, the sequencer and the top level; depends on nothing.
package bdo_pkg;

	localparam int FIELD_W = 16;
	localparam int TRIAL_W = 9;

	typedef enum logic [1:0] {
		REG_FULL_SIZE_X  = 2'd0,
		REG_FULL_SIZE_Y  = 2'd1,
		REG_FULL_SIZE_Z  = 2'd2,
		REG_WORKER_COUNT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               start;
		logic [FIELD_W-1:0] dividend;
		logic [FIELD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [FIELD_W-1:0] quotient;
		logic [FIELD_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [FIELD_W-1:0] grid_x;
		logic [FIELD_W-1:0] grid_y;
		logic [FIELD_W-1:0] grid_z;
		logic [FIELD_W-1:0] brick_size_x;
		logic [FIELD_W-1:0] brick_size_y;
		logic [FIELD_W-1:0] brick_size_z;
		logic [FIELD_W-1:0] offset_x;
		logic [FIELD_W-1:0] offset_y;
		logic [FIELD_W-1:0] offset_z;
		logic               rank_valid;
	} result_t;

endpackage

@@ rtl/core/bdo_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bdo_pkg for the request and response structs.
module bdo_divider import bdo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CntW = $clog2(FIELD_W);

	logic               busy_q;
	logic               done_q;
	logic [CntW-1:0]    cnt_q;
	logic [FIELD_W-1:0] rem_q;
	logic [FIELD_W-1:0] quo_q;
	logic [FIELD_W-1:0] div_q;

	logic [FIELD_W:0]   shifted;
	logic [FIELD_W:0]   diff;
	logic               fits;
	logic [FIELD_W-1:0] nxt_rem;

	assign shifted = {rem_q, quo_q[FIELD_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = !diff[FIELD_W];
	assign nxt_rem = fits ? diff[FIELD_W-1:0] : shifted[FIELD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				div_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= nxt_rem;
				quo_q <= {quo_q[FIELD_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(FIELD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

@@ rtl/core/bdo_sequencer.sv @@
// Sequencer that factors the worker count and works out one brick.
// Depends on bdo_pkg and drives the shared bdo_divider and one multiplier.
module bdo_sequencer import bdo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [FIELD_W-1:0] rank,
	input  logic [FIELD_W-1:0] count,
	input  logic [FIELD_W-1:0] full_x,
	input  logic [FIELD_W-1:0] full_y,
	input  logic [FIELD_W-1:0] full_z,
	input  logic               res_take,
	output logic               busy,
	output logic               res_valid,
	output result_t            res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FCHECK,
		S_FDIV,
		S_FTAIL,
		S_DISSUE,
		S_DWAIT,
		S_MUL,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		STEP_BS_X,
		STEP_BS_Y,
		STEP_BS_Z,
		STEP_ID_X,
		STEP_ID_YZ
	} step_t;

	state_t             state_q;
	step_t              step_q;
	logic [1:0]         axis_q;
	logic [1:0]         mk_q;
	logic [FIELD_W-1:0] rank_q;
	logic [FIELD_W-1:0] n_q;
	logic [TRIAL_W-1:0] i_q;
	logic [FIELD_W-1:0] q_q;
	logic               valid_q;
	logic [FIELD_W-1:0] g_q   [3];
	logic [FIELD_W-1:0] bs_q  [3];
	logic [FIELD_W-1:0] id_q  [3];
	logic [FIELD_W-1:0] off_q [3];

	div_req_t             dreq;
	div_rsp_t             drsp;
	logic [2*TRIAL_W-1:0] sq;
	logic                 past_root;
	logic [FIELD_W-1:0]   mul_a;
	logic [FIELD_W-1:0]   mul_b;
	logic [2*FIELD_W-1:0] prod;
	logic [1:0]           axis_nxt;

	bdo_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign sq        = i_q * i_q;
	assign past_root = sq > (2*TRIAL_W)'(n_q);
	assign axis_nxt  = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = n_q;
		dreq.divisor  = FIELD_W'(i_q);
		if (state_q == S_FCHECK) begin
			dreq.start = !past_root;
		end else if (state_q == S_DISSUE) begin
			dreq.start = 1'b1;
			unique case (step_q)
				STEP_BS_X: begin
					dreq.dividend = full_x;
					dreq.divisor  = g_q[0];
				end
				STEP_BS_Y: begin
					dreq.dividend = full_y;
					dreq.divisor  = g_q[1];
				end
				STEP_BS_Z: begin
					dreq.dividend = full_z;
					dreq.divisor  = g_q[2];
				end
				STEP_ID_X: begin
					dreq.dividend = rank_q;
					dreq.divisor  = g_q[0];
				end
				STEP_ID_YZ: begin
					dreq.dividend = q_q;
					dreq.divisor  = g_q[1];
				end
				default: begin
					dreq.dividend = rank_q;
					dreq.divisor  = g_q[0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			S_FDIV: begin
				mul_a = g_q[axis_q];
				mul_b = FIELD_W'(i_q);
			end
			S_FTAIL: begin
				mul_a = g_q[axis_q];
				mul_b = n_q;
			end
			S_MUL: begin
				mul_a = id_q[mk_q];
				mul_b = bs_q[mk_q];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= STEP_BS_X;
			axis_q  <= '0;
			mk_q    <= '0;
			rank_q  <= '0;
			n_q     <= '0;
			i_q     <= '0;
			q_q     <= '0;
			valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				g_q[k]   <= '0;
				bs_q[k]  <= '0;
				id_q[k]  <= '0;
				off_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rank_q  <= rank;
						n_q     <= (count == '0) ? FIELD_W'(1) : count;
						i_q     <= TRIAL_W'(2);
						axis_q  <= '0;
						valid_q <= rank < count;
						for (int k = 0; k < 3; k++) begin
							g_q[k] <= FIELD_W'(1);
						end
						state_q <= S_FCHECK;
					end
				end
				S_FCHECK: begin
					state_q <= past_root ? S_FTAIL : S_FDIV;
				end
				S_FDIV: begin
					if (drsp.done) begin
						if (drsp.remainder == '0) begin
							g_q[axis_q] <= prod[FIELD_W-1:0];
							n_q         <= drsp.quotient;
							axis_q      <= axis_nxt;
						end else begin
							i_q <= i_q + 1'b1;
						end
						state_q <= S_FCHECK;
					end
				end
				S_FTAIL: begin
					if (n_q != FIELD_W'(1)) begin
						g_q[axis_q] <= prod[FIELD_W-1:0];
					end
					step_q  <= STEP_BS_X;
					state_q <= S_DISSUE;
				end
				S_DISSUE: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (drsp.done) begin
						unique case (step_q)
							STEP_BS_X: bs_q[0] <= drsp.quotient;
							STEP_BS_Y: bs_q[1] <= drsp.quotient;
							STEP_BS_Z: bs_q[2] <= drsp.quotient;
							STEP_ID_X: begin
								id_q[0] <= drsp.remainder;
								q_q     <= drsp.quotient;
							end
							STEP_ID_YZ: begin
								id_q[1] <= drsp.remainder;
								id_q[2] <= drsp.quotient;
							end
							default: q_q <= drsp.quotient;
						endcase
						if (step_q == STEP_ID_YZ) begin
							mk_q    <= '0;
							state_q <= S_MUL;
						end else begin
							step_q  <= step_t'(step_q + 3'd1);
							state_q <= S_DISSUE;
						end
					end
				end
				S_MUL: begin
					off_q[mk_q] <= prod[FIELD_W-1:0];
					if (mk_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						mk_q <= mk_q + 2'd1;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign res_valid = state_q == S_DONE;

	assign res.grid_x       = g_q[0];
	assign res.grid_y       = g_q[1];
	assign res.grid_z       = g_q[2];
	assign res.brick_size_x = bs_q[0];
	assign res.brick_size_y = bs_q[1];
	assign res.brick_size_z = bs_q[2];
	assign res.offset_x     = off_q[0];
	assign res.offset_y     = off_q[1];
	assign res.offset_z     = off_q[2];
	assign res.rank_valid   = valid_q;

endmodule

@@ rtl/core/brick_decomposition_offsets.sv @@
// Top level of the brick decomposition block: configuration registers,
// request capture and the result register. Depends on bdo_pkg and bdo_sequencer.
//
// For one worker rank the block returns the grid of bricks that splits the
// volume among the configured worker count, the brick size on each axis and
// the first voxel of that rank's brick. One transaction is worked on at a time
// and req_stall is high from acceptance until the result is loaded into the
// output register. The shared divider sets the latency: the trial divisors
// run up to the square root of the count, then five more divisions and three
// multiplies follow. Small or highly composite counts finish soonest; a large
// prime count near 65535 takes longest.
module brick_decomposition_offsets import bdo_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [FIELD_W-1:0] cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [FIELD_W-1:0] worker_rank,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [FIELD_W-1:0] grid_x,
	output logic [FIELD_W-1:0] grid_y,
	output logic [FIELD_W-1:0] grid_z,
	output logic [FIELD_W-1:0] brick_size_x,
	output logic [FIELD_W-1:0] brick_size_y,
	output logic [FIELD_W-1:0] brick_size_z,
	output logic [FIELD_W-1:0] offset_x,
	output logic [FIELD_W-1:0] offset_y,
	output logic [FIELD_W-1:0] offset_z,
	output logic               rank_valid
);

	localparam logic [FIELD_W-1:0] CountMask = (COUNT_WIDTH >= FIELD_W) ?
		{FIELD_W{1'b1}} : FIELD_W'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic [FIELD_W-1:0] full_x_q;
	logic [FIELD_W-1:0] full_y_q;
	logic [FIELD_W-1:0] full_z_q;
	logic [FIELD_W-1:0] count_q;

	logic    busy;
	logic    seq_res_valid;
	logic    res_take;
	result_t seq_res;
	logic    rsp_valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_x_q <= FIELD_W'(1);
			full_y_q <= FIELD_W'(1);
			full_z_q <= FIELD_W'(1);
			count_q  <= FIELD_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FULL_SIZE_X:  full_x_q <= cfg_data;
				REG_FULL_SIZE_Y:  full_y_q <= cfg_data;
				REG_FULL_SIZE_Z:  full_z_q <= cfg_data;
				REG_WORKER_COUNT: count_q  <= cfg_data;
			endcase
		end
	end

	assign req_stall = busy;
	assign res_take  = seq_res_valid && (!rsp_valid_q || !rsp_stall);

	bdo_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_valid && !busy),
		.rank      (worker_rank),
		.count     (count_q & CountMask),
		.full_x    (full_x_q),
		.full_y    (full_y_q),
		.full_z    (full_z_q),
		.res_take  (res_take),
		.busy      (busy),
		.res_valid (seq_res_valid),
		.res       (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
			res_q       <= seq_res;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign grid_x       = res_q.grid_x;
	assign grid_y       = res_q.grid_y;
	assign grid_z       = res_q.grid_z;
	assign brick_size_x = res_q.brick_size_x;
	assign brick_size_y = res_q.brick_size_y;
	assign brick_size_z = res_q.brick_size_z;
	assign offset_x     = res_q.offset_x;
	assign offset_y     = res_q.offset_y;
	assign offset_z     = res_q.offset_z;
	assign rank_valid   = res_q.rank_valid;

endmodule

@@ rtl/core/bdo_checker.sv @@
// Port-level checker for the brick decomposition block and its bind.
// Depends on bdo_pkg and attaches to brick_decomposition_offsets.
module bdo_checker import bdo_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_wr_en,
	input logic [1:0]         cfg_index,
	input logic [FIELD_W-1:0] cfg_data,
	input logic               req_valid,
	input logic               req_stall,
	input logic [FIELD_W-1:0] worker_rank,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [FIELD_W-1:0] grid_x,
	input logic [FIELD_W-1:0] grid_y,
	input logic [FIELD_W-1:0] grid_z,
	input logic [FIELD_W-1:0] brick_size_x,
	input logic [FIELD_W-1:0] brick_size_y,
	input logic [FIELD_W-1:0] brick_size_z,
	input logic [FIELD_W-1:0] offset_x,
	input logic [FIELD_W-1:0] offset_y,
	input logic [FIELD_W-1:0] offset_z,
	input logic               rank_valid
);

	// A stalled result transaction stays valid and keeps grid_x, its offsets and rank_valid.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(grid_x) && $stable(offset_x)
			&& $stable(offset_y) && $stable(offset_z) && $stable(rank_valid))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while not going busy");

	a_grid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> grid_x != '0 && grid_y != '0 && grid_z != '0)
		else $error("zero grid size in result");

	a_single_brick_axis: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && grid_x == FIELD_W'(1) |-> offset_x == '0)
		else $error("nonzero x offset with a single brick along x");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without a computation");

endmodule

bind brick_decomposition_offsets bdo_checker u_bdo_checker (.*);

@@ sim/tb_brick_decomposition_offsets.sv @@
// Testbench for brick_decomposition_offsets: predicts the grid, brick size and offsets of
// every requested worker rank and checks each returned transaction field by field.
// Depends on bdo_pkg and the brick_decomposition_offsets top level only.
module tb_brick_decomposition_offsets;
	timeunit 1ns;
	timeprecision 1ps;

	import bdo_pkg::*;

	localparam int COUNT_WIDTH   = 16;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int HOLD_CYCLES   = 1500;
	localparam int SETTLE_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 50_000_000;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [1:0]         cfg_index   = REG_FULL_SIZE_X;
	logic [FIELD_W-1:0] cfg_data    = '0;
	logic               req_valid   = 1'b0;
	logic               req_stall;
	logic [FIELD_W-1:0] worker_rank = '0;
	logic               rsp_valid;
	logic               rsp_stall   = 1'b0;
	logic [FIELD_W-1:0] grid_x, grid_y, grid_z;
	logic [FIELD_W-1:0] brick_size_x, brick_size_y, brick_size_z;
	logic [FIELD_W-1:0] offset_x, offset_y, offset_z;
	logic               rank_valid;

	logic [FIELD_W-1:0] vol_extent [3] = '{16'd1, 16'd1, 16'd1};
	logic [FIELD_W-1:0] worker_total = 16'd1;
	result_t            expected_bricks [$];
	int                 errors = 0;
	int                 results_seen = 0;
	longint             cycles = 0;
	bit                 tx_idle_on = 1'b1;
	int                 rx_stall_pct = 20;
	int                 hold_req = 0;
	int                 hold_seen = 0;
	int                 hold_left = 0;
	int                 stall_left = 0;

	brick_decomposition_offsets #(.COUNT_WIDTH(COUNT_WIDTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .worker_rank(worker_rank),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.grid_x(grid_x), .grid_y(grid_y), .grid_z(grid_z),
		.brick_size_x(brick_size_x), .brick_size_y(brick_size_y),
		.brick_size_z(brick_size_z),
		.offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
		.rank_valid(rank_valid)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic result_t decompose(input logic [FIELD_W-1:0] rank);
		longint unsigned count, n, d, r;
		longint unsigned g [3];
		longint unsigned bs [3];
		longint unsigned idx [3];
		int axis;
		result_t res;
		count = longint'(worker_total) & ((64'd1 << COUNT_WIDTH) - 1);
		n = (count == 0) ? 1 : count;
		r = rank;
		g[0] = 1;
		g[1] = 1;
		g[2] = 1;
		axis = 0;
		d = 2;
		while (d * d <= n) begin
			if (n % d == 0) begin
				g[axis] *= d;
				n /= d;
				axis = (axis + 1) % 3;
				d = 2;
			end else begin
				d++;
			end
		end
		if (n != 1)
			g[axis] *= n;
		for (int k = 0; k < 3; k++)
			bs[k] = vol_extent[k] / g[k];
		idx[0] = r % g[0];
		idx[1] = (r / g[0]) % g[1];
		idx[2] = r / (g[0] * g[1]);
		res.grid_x       = g[0][15:0];
		res.grid_y       = g[1][15:0];
		res.grid_z       = g[2][15:0];
		res.brick_size_x = bs[0][15:0];
		res.brick_size_y = bs[1][15:0];
		res.brick_size_z = bs[2][15:0];
		res.offset_x     = 16'(idx[0] * bs[0]);
		res.offset_y     = 16'(idx[1] * bs[1]);
		res.offset_z     = 16'(idx[2] * bs[2]);
		res.rank_valid   = (r < count);
		return res;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 20);
		return $urandom_range(40, 200);
	endfunction

	task automatic report_error(input string msg);
		$display("%0t ns: %s", $realtime, msg);
		errors++;
	endtask

	task automatic compare_field(input string name, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] want);
		if (got !== want)
			report_error($sformatf("result %0d: %s is %0d, expected %0d",
				results_seen, name, got, want));
	endtask

	task automatic check_brick();
		result_t want;
		if (expected_bricks.size() == 0) begin
			report_error("transaction returned with no rank outstanding");
			return;
		end
		want = expected_bricks.pop_front();
		compare_field("grid_x", grid_x, want.grid_x);
		compare_field("grid_y", grid_y, want.grid_y);
		compare_field("grid_z", grid_z, want.grid_z);
		compare_field("brick_size_x", brick_size_x, want.brick_size_x);
		compare_field("brick_size_y", brick_size_y, want.brick_size_y);
		compare_field("brick_size_z", brick_size_z, want.brick_size_z);
		compare_field("offset_x", offset_x, want.offset_x);
		compare_field("offset_y", offset_y, want.offset_y);
		compare_field("offset_z", offset_z, want.offset_z);
		compare_field("rank_valid", 16'(rank_valid), 16'(want.rank_valid));
		results_seen++;
	endtask

	// The receiver checks at each edge and then decides whether to stall the next cycle.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_brick();
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall_left = 0;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < rx_stall_pct) begin
			stall_left = idle_len() - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_rank(input logic [FIELD_W-1:0] rank);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 1) == 1) ? idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		worker_rank <= rank;
		do @(posedge clk); while (req_stall);
		expected_bricks.push_back(decompose(rank));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_bricks.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [FIELD_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_FULL_SIZE_X:  vol_extent[0] = value;
			REG_FULL_SIZE_Y:  vol_extent[1] = value;
			REG_FULL_SIZE_Z:  vol_extent[2] = value;
			REG_WORKER_COUNT: worker_total = value;
			default: ;
		endcase
	endtask

	// Registers change only once every outstanding transaction has returned.
	task automatic set_config(input logic [FIELD_W-1:0] sx, input logic [FIELD_W-1:0] sy,
			input logic [FIELD_W-1:0] sz, input logic [FIELD_W-1:0] count);
		drain();
		write_reg(REG_FULL_SIZE_X, sx);
		write_reg(REG_FULL_SIZE_Y, sy);
		write_reg(REG_FULL_SIZE_Z, sz);
		write_reg(REG_WORKER_COUNT, count);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [FIELD_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 16'd0;
		if (r < 10)
			return 16'hFFFF;
		if (r < 15)
			return 16'd1;
		if (r < 50)
			return 16'($urandom_range(1, 255));
		return 16'($urandom_range(0, 65535));
	endfunction

	// Large prime counts are slow, so most counts are small or built from small primes.
	function automatic logic [FIELD_W-1:0] pick_count();
		int r, n, p, k;
		int primes [4] = '{2, 3, 5, 7};
		r = $urandom_range(0, 99);
		if (r < 5)
			return 16'd0;
		if (r < 35)
			return 16'($urandom_range(1, 64));
		if (r < 65) begin
			n = 1;
			k = $urandom_range(0, 16);
			repeat (k) begin
				p = primes[$urandom_range(0, 3)];
				if (n * p <= 65535)
					n *= p;
			end
			return 16'(n);
		end
		if (r < 90)
			return 16'($urandom_range(1, 4096));
		return 16'($urandom_range(4097, 65535));
	endfunction

	function automatic logic [FIELD_W-1:0] pick_rank(input logic [FIELD_W-1:0] count);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70 && count != 0)
			return 16'($urandom_range(0, count - 1));
		if (r < 80)
			return count;
		if (r < 85)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic test_reset_defaults();
		send_rank(16'd0);
		send_rank(16'd1);
		send_rank(16'hFFFF);
	endtask

	task automatic test_field_extremes();
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_rank(16'd0);
		send_rank(16'd770);
		send_rank(16'hFFFE);
		send_rank(16'hFFFF);
		set_config(16'hFFFF, 16'd1, 16'hFFFF, 16'd32768);
		send_rank(16'd32767);
		send_rank(16'd43690);
	endtask

	task automatic test_zero_count();
		set_config(16'd100, 16'd200, 16'd300, 16'd0);
		send_rank(16'd0);
		send_rank(16'd5);
		send_rank(16'hFFFF);
	endtask

	task automatic test_zero_size();
		set_config(16'd0, 16'd0, 16'd0, 16'd12);
		send_rank(16'd0);
		send_rank(16'd11);
		send_rank(16'd12);
	endtask

	task automatic test_prime_counts();
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd65521);
		send_rank(16'd0);
		send_rank(16'd65520);
		send_rank(16'd65521);
		set_config(16'd9, 16'd10, 16'd11, 16'd7);
		send_rank(16'd6);
		send_rank(16'd7);
		set_config(16'd17, 16'd18, 16'd19, 16'd4);
		send_rank(16'd3);
		set_config(16'd17, 16'd18, 16'd19, 16'd8);
		send_rank(16'd7);
		send_rank(16'd9);
	endtask

	// The receiver holds off long enough for the block to stall its request side.
	task automatic test_output_backpressure();
		set_config(16'd64, 16'd48, 16'd32, 16'd24);
		tx_idle_on = 1'b0;
		hold_req <= hold_req + 1;
		repeat (12) send_rank(16'($urandom_range(0, 23)));
		drain();
		tx_idle_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		set_config(16'd1000, 16'd999, 16'd998, 16'd360);
		repeat (8) send_rank(pick_rank(16'd360));
		drain();
		repeat (8) send_rank(pick_rank(16'd360));
		drain();
	endtask

	task automatic test_random_decompositions();
		int sent, n;
		bit quiet;
		logic [FIELD_W-1:0] count;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			count = pick_count();
			set_config(pick_size(), pick_size(), pick_size(), count);
			quiet = ($urandom_range(0, 3) == 0);
			tx_idle_on = !quiet;
			rx_stall_pct <= quiet ? 0 : 20;
			n = (count > 4096) ? $urandom_range(2, 5) : $urandom_range(15, 40);
			repeat (n) send_rank(pick_rank(count));
			sent += n;
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_zero_count();
		test_zero_size();
		test_prime_counts();
		test_output_backpressure();
		test_drain_pause();
		test_random_decompositions();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
